FILE: rtl/core/bsr_pkg.sv
`default_nettype none
package bsr_pkg;

   localparam logic [1:0] OP_BITS  = 2'd0;
   localparam logic [1:0] OP_INT   = 2'd1;
   localparam logic [1:0] OP_ALIGN = 2'd2;

   localparam logic [1:0] KIND_BITS  = 2'd0;
   localparam logic [1:0] KIND_INT   = 2'd1;
   localparam logic [1:0] KIND_ALIGN = 2'd2;
   localparam logic [1:0] KIND_NOP   = 2'd3;

   localparam int WIN_BYTES   = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [6:0] MAX_BIT_COUNT  = 7'd64;
   localparam logic [3:0] MAX_BYTE_COUNT = 4'd8;

   typedef struct packed {
      logic [1:0]  kind;
      logic [6:0]  bit_count;
      logic [3:0]  byte_count;
      logic        msb_first;
      logic        sign_extend;
      logic [63:0] window;
      logic [3:0]  bytes_available;
   } bsr_item_type;

   typedef struct packed {
      logic [6:0] bits;
      logic [2:0] count;
   } bsr_state_type;

   function automatic logic [63:0] mask64(input logic [6:0] n);
      logic [64:0] m;
      m = (65'd1 << n) - 65'd1;
      return m[63:0];
   endfunction

   function automatic logic [63:0] byte_reverse(input logic [63:0] w);
      logic [63:0] r;
      for (int i = 0; i < WIN_BYTES; i++) begin
         r[8*(WIN_BYTES-1-i) +: 8] = w[8*i +: 8];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bitfield_stream_reader_unit.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  opcode, counts, flags, window, bytes available
// rsp_      out        rsp_valid / rsp_stall  value, bytes_consumed, end_of_stream
//
// One transaction per cycle unless stalled; a request is queued, then its result registered.
// The front clamps and classifies, a two-entry queue decouples it from the back,
// which applies the leftover-bit state and fills the output register.
// Synchronous active-high reset clears the leftover state, queue and output valid.
// req_stall rises only when the queue is full; rsp_stall holds the output register.
`default_nettype none
module bitfield_stream_reader_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [6:0]  req_bit_count,
   input  wire logic [3:0]  req_byte_count,
   input  wire logic        req_msb_first,
   input  wire logic        req_sign_extend,
   input  wire logic [63:0] req_window,
   input  wire logic [3:0]  req_bytes_available,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [63:0] rsp_value,
   output      logic [3:0]  rsp_bytes_consumed,
   output      logic        rsp_end_of_stream
);
   import bsr_pkg::*;

   logic          push;
   bsr_item_type  push_item;
   logic          full;
   logic          head_valid;
   bsr_item_type  head_item;
   logic          pop;
   bsr_state_type state;

   bsr_front u_front (
      .req_valid           (req_valid),
      .req_opcode          (req_opcode),
      .req_bit_count       (req_bit_count),
      .req_byte_count      (req_byte_count),
      .req_msb_first       (req_msb_first),
      .req_sign_extend     (req_sign_extend),
      .req_window          (req_window),
      .req_bytes_available (req_bytes_available),
      .push                (push),
      .push_item           (push_item)
   );

   bsr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (full),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop)
   );

   bsr_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_item          (head_item),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_value          (rsp_value),
      .rsp_bytes_consumed (rsp_bytes_consumed),
      .rsp_end_of_stream  (rsp_end_of_stream),
      .state              (state)
   );

   assign req_stall = full;

`ifndef SYNTHESIS
   a_eos_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_stream |-> rsp_value == 64'd0 && rsp_bytes_consumed == 4'd0)
      else $error("end of stream transaction carries data");

   a_consumed_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_bytes_consumed <= MAX_BYTE_COUNT)
      else $error("bytes consumed out of range");

   a_leftover_clean: assert property (@(posedge clock) disable iff (reset)
      (state.bits & ~7'((8'd1 << state.count) - 8'd1)) == 7'd0)
      else $error("leftover bits above count not zero");

   a_pop_fills: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid)
      else $error("popped transaction did not reach output");
`endif

endmodule
`default_nettype wire

FILE: rtl/core/bsr_front.sv
`default_nettype none
module bsr_front (
   input  wire logic                  req_valid,
   input  wire logic [1:0]            req_opcode,
   input  wire logic [6:0]            req_bit_count,
   input  wire logic [3:0]            req_byte_count,
   input  wire logic                  req_msb_first,
   input  wire logic                  req_sign_extend,
   input  wire logic [63:0]           req_window,
   input  wire logic [3:0]            req_bytes_available,
   output      logic                  push,
   output      bsr_pkg::bsr_item_type push_item
);
   import bsr_pkg::*;

   logic [6:0] n_clamp;
   logic [3:0] len_clamp;
   logic [3:0] avail_clamp;

   always_comb begin
      n_clamp     = (req_bit_count > MAX_BIT_COUNT) ? MAX_BIT_COUNT : req_bit_count;
      len_clamp   = (req_byte_count > MAX_BYTE_COUNT) ? MAX_BYTE_COUNT : req_byte_count;
      avail_clamp = (req_bytes_available > MAX_BYTE_COUNT) ? MAX_BYTE_COUNT
                                                           : req_bytes_available;
      push_item.bit_count       = n_clamp;
      push_item.byte_count      = len_clamp;
      push_item.msb_first       = req_msb_first;
      push_item.sign_extend     = req_sign_extend;
      push_item.window          = req_window;
      push_item.bytes_available = avail_clamp;
      case (req_opcode)
         OP_BITS: begin
            push_item.kind = (n_clamp == 7'd0) ? KIND_NOP : KIND_BITS;
         end
         OP_INT: begin
            push_item.kind = (len_clamp == 4'd0) ? KIND_NOP : KIND_INT;
         end
         OP_ALIGN: begin
            push_item.kind = KIND_ALIGN;
         end
         default: begin
            push_item.kind = KIND_NOP;
         end
      endcase
      push = req_valid;
   end

endmodule
`default_nettype wire

FILE: rtl/core/bsr_queue.sv
`default_nettype none
module bsr_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire bsr_pkg::bsr_item_type push_item,
   output      logic                  full,
   output      logic                  head_valid,
   output      bsr_pkg::bsr_item_type head_item,
   input  wire logic                  pop
);
   import bsr_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   bsr_item_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]          count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   always_comb begin
      full       = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
      head_valid = (count_ff != '0);
      head_item  = slot_ff[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;
      wr_ptr_in  = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in   = count_ff + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/bsr_back.sv
`default_nettype none
module bsr_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   head_valid,
   input  wire bsr_pkg::bsr_item_type  head_item,
   output      logic                   pop,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic [63:0]            rsp_value,
   output      logic [3:0]             rsp_bytes_consumed,
   output      logic                   rsp_end_of_stream,
   output      bsr_pkg::bsr_state_type state
);
   import bsr_pkg::*;

   bsr_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [63:0]   value_ff, value_in;
   logic [3:0]    consumed_ff, consumed_in;
   logic          eos_ff, eos_in;

   logic          load;
   logic [6:0]    bits;
   logic [2:0]    left;
   logic [6:0]    n;
   logic [63:0]   rev;
   logic [6:0]    d;
   logic [6:0]    d_round;
   logic [3:0]    k;
   logic [6:0]    r_full;
   logic [2:0]    r;
   logic [70:0]   s_be;
   logic [70:0]   t_le;
   logic [7:0]    sa_be;
   logic [6:0]    sa_nb;
   logic [70:0]   be_val_sh;
   logic [70:0]   be_nb_sh;
   logic [70:0]   le_nb_sh;
   logic [7:0]    r_mask_w;
   logic [6:0]    r_mask;
   logic [63:0]   int_val;
   logic [6:0]    len_bits;
   logic [6:0]    sign_idx;

   always_comb begin
      load = !rsp_valid_ff || !rsp_stall;
      pop  = head_valid && load;

      left = state_ff.count;
      bits = state_ff.bits & 7'((8'd1 << left) - 8'd1);
      n    = head_item.bit_count;
      rev  = byte_reverse(head_item.window);

      d       = n - {4'd0, left};
      d_round = d + 7'd7;
      k       = (n > {4'd0, left}) ? d_round[6:3] : 4'd0;
      r_full  = {4'd0, left} + {k, 3'b000} - n;
      r       = r_full[2:0];
      r_mask_w = (8'd1 << r) - 8'd1;
      r_mask   = r_mask_w[6:0];

      s_be      = {bits, rev};
      sa_be     = 8'd64 + {5'd0, left} - {1'b0, n};
      sa_nb     = 7'd64 - {k, 3'b000};
      be_val_sh = s_be >> sa_be;
      be_nb_sh  = s_be >> sa_nb;

      t_le     = ({7'd0, head_item.window} << left) | {64'd0, bits};
      le_nb_sh = t_le >> n;

      len_bits = {head_item.byte_count, 3'b000};
      sign_idx = len_bits - 7'd1;
      int_val  = head_item.msb_first ? (rev >> (7'd64 - len_bits))
                                     : (head_item.window & mask64(len_bits));
      if (head_item.sign_extend && (head_item.byte_count != MAX_BYTE_COUNT)
          && int_val[sign_idx[5:0]]) begin
         int_val = int_val | ~mask64(len_bits);
      end

      state_in    = state_ff;
      value_in    = '0;
      consumed_in = '0;
      eos_in      = 1'b0;
      case (head_item.kind)
         KIND_BITS: begin
            if (k > head_item.bytes_available) begin
               eos_in = 1'b1;
            end else begin
               consumed_in    = k;
               state_in.count = r;
               if (head_item.msb_first) begin
                  value_in      = be_val_sh[63:0] & mask64(n);
                  state_in.bits = be_nb_sh[6:0] & r_mask;
               end else begin
                  value_in      = t_le[63:0] & mask64(n);
                  state_in.bits = le_nb_sh[6:0] & r_mask;
               end
            end
         end
         KIND_INT: begin
            if (head_item.byte_count > head_item.bytes_available) begin
               eos_in = 1'b1;
            end else begin
               value_in    = int_val;
               consumed_in = head_item.byte_count;
            end
         end
         KIND_ALIGN: begin
            state_in = '0;
         end
         default: begin
            state_in = state_ff;
         end
      endcase

      rsp_valid_in = pop ? 1'b1 : (load ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         value_ff    <= value_in;
         consumed_ff <= consumed_in;
         eos_ff      <= eos_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_value          = value_ff;
   assign rsp_bytes_consumed = consumed_ff;
   assign rsp_end_of_stream  = eos_ff;
   assign state              = state_ff;

endmodule
`default_nettype wire

FILE: tb/bitfield_stream_reader_unit_tb.sv
`timescale 1ns / 1ps
module bitfield_stream_reader_unit_tb;
   import bsr_pkg::*;

   localparam logic [1:0] OP_NOP = 2'd3;
   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_PER_PHASE = 667;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [6:0]  bit_count;
      logic [3:0]  byte_count;
      logic        msb_first;
      logic        sign_extend;
      logic [63:0] window;
      logic [3:0]  bytes_available;
   } field_request_type;

   typedef struct packed {
      logic [63:0] value;
      logic [3:0]  bytes_consumed;
      logic        end_of_stream;
   } field_result_type;

   typedef struct packed {
      field_request_type request;
      logic              typed;
      field_result_type  result;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = '0;
   logic [6:0]  req_bit_count = '0;
   logic [3:0]  req_byte_count = '0;
   logic        req_msb_first = 1'b0;
   logic        req_sign_extend = 1'b0;
   logic [63:0] req_window = '0;
   logic [3:0]  req_bytes_available = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_value;
   logic [3:0]  rsp_bytes_consumed;
   logic        rsp_end_of_stream;

   logic [6:0]  held_bits = '0;
   logic [2:0]  held_count = '0;
   field_result_type awaited_fields [$];
   int          mismatch_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   directed_row_type directed_plan [0:DIRECTED_ROWS-1] = '{
      '{'{OP_BITS, 7'd8, 4'd1, 1'b1, 1'b0, 64'h00000000000000A5, 4'd1}, 1'b1,
        '{64'h00000000000000A5, 4'd1, 1'b0}},
      '{'{OP_INT, 7'd1, 4'd8, 1'b0, 1'b0, 64'hFFFFFFFFFFFFFFFF, 4'd8}, 1'b1,
        '{64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b0}},
      '{'{OP_INT, 7'd1, 4'd1, 1'b0, 1'b1, 64'h0000000000000080, 4'd1}, 1'b1,
        '{64'hFFFFFFFFFFFFFF80, 4'd1, 1'b0}},
      '{'{OP_INT, 7'd1, 4'd1, 1'b0, 1'b1, 64'h000000000000007F, 4'd1}, 1'b1,
        '{64'h000000000000007F, 4'd1, 1'b0}},
      '{'{OP_INT, 7'd1, 4'd2, 1'b1, 1'b0, 64'h0000000000003412, 4'd2}, 1'b1,
        '{64'h0000000000001234, 4'd2, 1'b0}},
      '{'{OP_INT, 7'd1, 4'd3, 1'b0, 1'b0, 64'h0000000000FFFFFF, 4'd2}, 1'b1,
        '{64'h0, 4'd0, 1'b1}},
      '{'{OP_INT, 7'd1, 4'd0, 1'b0, 1'b1, 64'h00000000000000FF, 4'd8}, 1'b1,
        '{64'h0, 4'd0, 1'b0}},
      '{'{OP_INT, 7'd1, 4'd15, 1'b0, 1'b0, 64'h0123456789ABCDEF, 4'd8}, 1'b1,
        '{64'h0123456789ABCDEF, 4'd8, 1'b0}},
      '{'{OP_INT, 7'd1, 4'd15, 1'b1, 1'b1, 64'h0123456789ABCDEF, 4'd15}, 1'b0, '0},
      '{'{OP_NOP, 7'd127, 4'd15, 1'b1, 1'b1, 64'hFFFFFFFFFFFFFFFF, 4'd15}, 1'b1,
        '{64'h0, 4'd0, 1'b0}},
      '{'{OP_BITS, 7'd0, 4'd1, 1'b1, 1'b0, 64'h00000000000000FF, 4'd8}, 1'b1,
        '{64'h0, 4'd0, 1'b0}},
      '{'{OP_BITS, 7'd3, 4'd1, 1'b1, 1'b0, 64'h00000000000000E0, 4'd1}, 1'b1,
        '{64'h0000000000000007, 4'd1, 1'b0}},
      '{'{OP_BITS, 7'd64, 4'd1, 1'b0, 1'b0, 64'hDEADBEEF01234567, 4'd8}, 1'b0, '0},
      '{'{OP_BITS, 7'd127, 4'd1, 1'b1, 1'b0, 64'h5A5AC3C30F0F9669, 4'd8}, 1'b0, '0},
      '{'{OP_BITS, 7'd64, 4'd1, 1'b1, 1'b0, 64'hFFFFFFFFFFFFFFFF, 4'd7}, 1'b1,
        '{64'h0, 4'd0, 1'b1}},
      '{'{OP_ALIGN, 7'd64, 4'd8, 1'b1, 1'b1, 64'hFFFFFFFFFFFFFFFF, 4'd15}, 1'b1,
        '{64'h0, 4'd0, 1'b0}},
      '{'{OP_BITS, 7'd64, 4'd1, 1'b1, 1'b0, 64'hFFFFFFFFFFFFFFFF, 4'd8}, 1'b1,
        '{64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b0}},
      '{'{OP_BITS, 7'd1, 4'd1, 1'b0, 1'b0, 64'h0000000000000001, 4'd1}, 1'b1,
        '{64'h0000000000000001, 4'd1, 1'b0}},
      '{'{OP_BITS, 7'd7, 4'd1, 1'b1, 1'b0, 64'h0, 4'd0}, 1'b0, '0},
      '{'{OP_BITS, 7'd5, 4'd1, 1'b0, 1'b0, 64'h00000000000000B7, 4'd1}, 1'b0, '0},
      '{'{OP_BITS, 7'd12, 4'd1, 1'b1, 1'b0, 64'h0000000000009C3A, 4'd2}, 1'b0, '0},
      '{'{OP_BITS, 7'd8, 4'd1, 1'b1, 1'b0, 64'h0, 4'd0}, 1'b0, '0},
      '{'{OP_INT, 7'd1, 4'd8, 1'b1, 1'b1, 64'h00000000000000C1, 4'd15}, 1'b0, '0},
      '{'{OP_BITS, 7'd64, 4'd0, 1'b0, 1'b1, 64'hFFFFFFFFFFFFFFFF, 4'd15}, 1'b0, '0},
      '{'{OP_ALIGN, 7'd0, 4'd0, 1'b0, 1'b0, 64'h0, 4'd0}, 1'b1,
        '{64'h0, 4'd0, 1'b0}}
   };

   bitfield_stream_reader_unit uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_bit_count       (req_bit_count),
      .req_byte_count      (req_byte_count),
      .req_msb_first       (req_msb_first),
      .req_sign_extend     (req_sign_extend),
      .req_window          (req_window),
      .req_bytes_available (req_bytes_available),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_value           (rsp_value),
      .rsp_bytes_consumed  (rsp_bytes_consumed),
      .rsp_end_of_stream   (rsp_end_of_stream)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [63:0] low_mask(input int unsigned n);
      if (n >= 64) begin
         return '1;
      end
      return (64'd1 << n) - 64'd1;
   endfunction

   function automatic logic [63:0] window_msb_first(input logic [63:0] w,
                                                    input int unsigned k);
      logic [63:0] acc;
      acc = '0;
      for (int i = 0; i < k && i < 8; i++) begin
         acc = (acc << 8) | {56'd0, w[8*i +: 8]};
      end
      return acc;
   endfunction

   function automatic field_result_type extract_field(input field_request_type rq);
      field_result_type res;
      int unsigned      avail, n, len, left, k, r, sh;
      logic [63:0]      bits, fetched, next_bits, hi;
      res = '0;
      avail = {28'd0, rq.bytes_available};
      if (avail > 8) begin
         avail = 8;
      end
      case (rq.opcode)
         OP_BITS: begin
            left = {29'd0, held_count};
            bits = {57'd0, held_bits} & low_mask(left);
            n = {25'd0, rq.bit_count};
            if (n > 64) begin
               n = 64;
            end
            if (n != 0) begin
               k = (n > left) ? (n - left + 7) / 8 : 0;
               if (k > avail) begin
                  res.end_of_stream = 1'b1;
               end else begin
                  r = left + 8 * k - n;
                  if (k == 0) begin
                     if (rq.msb_first) begin
                        res.value = (bits >> r) & low_mask(n);
                        next_bits = bits & low_mask(r);
                     end else begin
                        res.value = bits & low_mask(n);
                        next_bits = (bits >> n) & low_mask(r);
                     end
                  end else if (rq.msb_first) begin
                     fetched = window_msb_first(rq.window, k);
                     sh = 8 * k - r;
                     hi = (sh >= 64) ? 64'd0 : (bits << sh);
                     res.value = (hi | (fetched >> r)) & low_mask(n);
                     next_bits = fetched & low_mask(r);
                  end else begin
                     fetched = rq.window & low_mask(8 * k);
                     res.value = (bits | (fetched << left)) & low_mask(n);
                     next_bits = (r == 0) ? 64'd0 : ((fetched >> (n - left)) & low_mask(r));
                  end
                  held_bits = next_bits[6:0];
                  held_count = r[2:0];
                  res.bytes_consumed = k[3:0];
               end
            end
         end
         OP_INT: begin
            len = {28'd0, rq.byte_count};
            if (len > 8) begin
               len = 8;
            end
            if (len > avail) begin
               res.end_of_stream = 1'b1;
            end else if (len != 0) begin
               res.value = rq.msb_first ? window_msb_first(rq.window, len)
                                        : rq.window & low_mask(8 * len);
               if (rq.sign_extend && len < 8 && res.value[8 * len - 1]) begin
                  res.value = res.value | ~low_mask(8 * len);
               end
               res.bytes_consumed = len[3:0];
            end
         end
         OP_ALIGN: begin
            held_bits = '0;
            held_count = '0;
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic field_request_type random_request();
      field_request_type rq;
      int unsigned       roll;
      rq.window = {$urandom, $urandom};
      rq.msb_first = 1'($urandom_range(0, 1));
      rq.sign_extend = 1'($urandom_range(0, 1));
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
         rq.opcode = OP_BITS;
      end else if (roll < 82) begin
         rq.opcode = OP_INT;
      end else if (roll < 94) begin
         rq.opcode = OP_ALIGN;
      end else begin
         rq.opcode = OP_NOP;
      end
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
         rq.bit_count = 7'($urandom_range(1, 16));
      end else if (roll < 90) begin
         rq.bit_count = 7'($urandom_range(17, 64));
      end else begin
         rq.bit_count = 7'($urandom_range(0, 127));
      end
      rq.byte_count = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(1, 8))
                                                   : 4'($urandom_range(0, 15));
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         rq.bytes_available = 4'd8;
      end else if (roll < 94) begin
         rq.bytes_available = 4'($urandom_range(0, 8));
      end else begin
         rq.bytes_available = 4'($urandom_range(0, 15));
      end
      return rq;
   endfunction

   task automatic send_request(input field_request_type rq, input logic typed,
                               input field_result_type want);
      field_result_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_opcode = rq.opcode;
      req_bit_count = rq.bit_count;
      req_byte_count = rq.byte_count;
      req_msb_first = rq.msb_first;
      req_sign_extend = rq.sign_extend;
      req_window = rq.window;
      req_bytes_available = rq.bytes_available;
      req_valid = 1'b1;
      while (req_stall) begin
         @(negedge clock);
      end
      @(posedge clock);
      predicted = extract_field(rq);
      awaited_fields.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      field_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_fields.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("unexpected transaction: value %h consumed %0d eos %0b",
                        rsp_value, rsp_bytes_consumed, rsp_end_of_stream);
            end
         end else begin
            want = awaited_fields.pop_front();
            if (rsp_value !== want.value || rsp_bytes_consumed !== want.bytes_consumed
                || rsp_end_of_stream !== want.end_of_stream) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("mismatch: expected value %h consumed %0d eos %0b, ",
                           want.value, want.bytes_consumed, want.end_of_stream,
                           "got value %h consumed %0d eos %0b",
                           rsp_value, rsp_bytes_consumed, rsp_end_of_stream);
               end
            end
         end
      end
   end

   initial begin
      #5000000;
      $display("bitfield_stream_reader_unit regression: fail");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_idle_pct = 19;
      recv_stall_pct = 83;
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_request(directed_plan[i].request, directed_plan[i].typed,
                      directed_plan[i].result);
      end
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 19;
               recv_stall_pct = 83;
            end
            1: begin
               send_idle_pct = 83;
               recv_stall_pct = 19;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            send_request(random_request(), 1'b0, '0);
         end
         // hold off until the pipeline drains
         req_valid = 1'b0;
         while (awaited_fields.size() != 0) begin
            @(negedge clock);
         end
      end
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && awaited_fields.size() == 0) begin
         $display("bitfield_stream_reader_unit regression: pass");
      end else begin
         $display("bitfield_stream_reader_unit regression: fail");
      end
      $finish;
   end

endmodule
